FILE: rtl/core/fspa_pkg.sv
`default_nettype none
package fspa_pkg;

    localparam int MAX_SLOTS     = 4096;
    localparam int POINTER_BYTES = 8;
    localparam int ALIGN_BYTES   = 16;

    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int LINK_W   = SLOT_W + 1;
    localparam int TOTAL_W  = 17;
    localparam int REQ_W    = 13;
    localparam int SIZE_W   = 17;
    localparam int OFFSET_W = 16;
    localparam int STATUS_W = 2;
    localparam int DIV_W    = 17;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = TOTAL_W'(65536);
    localparam logic [TOTAL_W-1:0] TOTAL_RESET   = TOTAL_W'(65536);
    localparam logic [REQ_W-1:0]   REQ_RESET     = REQ_W'(4096);
    localparam logic [LINK_W-1:0]  LINK_NULL     = LINK_W'(MAX_SLOTS);

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REQUESTED_SLOTS = CFG_IDX_W'(1);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_TOO_LARGE   = 2'd2,
        ST_NOT_IN_POOL = 2'd3
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [SLOT_W-1:0]     slot_number;
        logic [OFFSET_W-1:0]   byte_offset;
    } t_rsp;

endpackage
`default_nettype wire

FILE: rtl/core/fspa_if.sv
`default_nettype none
interface fspa_req_if;
    import fspa_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [TOTAL_W-1:0]  request_bytes;
    logic [SLOT_W-1:0]   slot_to_free;

    modport source (output valid, output opcode, output request_bytes,
                    output slot_to_free, input ready);
    modport sink   (input valid, input opcode, input request_bytes,
                    input slot_to_free, output ready);
endinterface

interface fspa_rsp_if;
    import fspa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_number;
    logic [OFFSET_W-1:0] byte_offset;

    modport source (output valid, output status, output slot_number,
                    output byte_offset, input ready);
    modport sink   (input valid, input status, input slot_number,
                    input byte_offset, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fixed_slot_pool_allocator_core.sv
`default_nettype none
// channel   dir   handshake      payload
// i_req     in    valid/ready    opcode, request_bytes, slot_to_free
// o_rsp     out   valid/ready    status, slot_number, byte_offset
// i_cfg_*   in    write enable   index, data (no read-back)
//
// a free completes in S_RUN; an allocate also passes through S_POP: the link of the popped slot comes
// back from the registered link memory before the head can move on.
// after reset and after each config write the block derives slot size and
// count with a shared 17-step divider (twice) and then relinks all 4096
// entries one a cycle; ready stays low throughout.
// one result register; a new transaction is taken while it is drained.
module fixed_slot_pool_allocator_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    fspa_req_if.sink                       i_req,
    fspa_rsp_if.source                     o_rsp,
    input  wire                            i_cfg_we,
    input  wire [fspa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [fspa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fspa_pkg::*;

    typedef enum logic [5:0] {
        S_INIT      = 6'b000001,
        S_DIV_SIZE  = 6'b000010,
        S_DIV_COUNT = 6'b000100,
        S_LINK      = 6'b001000,
        S_RUN       = 6'b010000,
        S_POP       = 6'b100000
    } t_state;

    localparam logic [SIZE_W-1:0] ALIGN_MASK = ~(SIZE_W'(ALIGN_BYTES - 1));

    t_state                r_state, n_state;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic [REQ_W-1:0]      r_req, n_req;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [LINK_W-1:0]     r_count, n_count;
    logic [LINK_W-1:0]     r_head, n_head;
    logic [DIV_W-1:0]      r_rem, n_rem;
    logic [DIV_W-1:0]      r_quo, n_quo;
    logic [DIV_W-1:0]      r_dvs, n_dvs;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [LINK_W-1:0]     r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;

    logic [LINK_W-1:0]     mem [MAX_SLOTS];
    logic [LINK_W-1:0]     r_rdata;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [LINK_W-1:0]     mem_wdata;
    logic [SLOT_W-1:0]     mem_raddr;

    logic                  in_fire;
    logic [TOTAL_W-1:0]    total_sat;
    logic [DIV_W-1:0]      req_clamp;
    logic [DIV_W:0]        rem_sh;
    logic                  rem_ge;
    logic [DIV_W:0]        rem_sub;
    logic [DIV_W-1:0]      rem_nx;
    logic [DIV_W-1:0]      quo_nx;
    logic [SIZE_W-1:0]     size_min;
    logic [SIZE_W-1:0]     size_al;
    logic [LINK_W-1:0]     idx_inc;
    logic [SLOT_W-1:0]     mul_slot;
    logic [SLOT_W+SIZE_W-1:0] product;

    assign in_fire     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_RUN) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.slot_number = r_out.slot_number;
    assign o_rsp.byte_offset = r_out.byte_offset;

    // config clamping feeding the divider
    always_comb begin
        total_sat = (r_total > TOTAL_MAX) ? TOTAL_MAX : r_total;
        req_clamp = DIV_W'(r_req);
        if (req_clamp > DIV_W'(total_sat)) begin
            req_clamp = DIV_W'(total_sat);
        end
        if (req_clamp == '0) begin
            req_clamp = DIV_W'(1);
        end
    end

    // one restoring division step
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        rem_ge  = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
        rem_nx  = rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quo_nx  = {r_quo[DIV_W-2:0], rem_ge};
        size_min = (SIZE_W'(quo_nx) < SIZE_W'(POINTER_BYTES)) ?
                   SIZE_W'(POINTER_BYTES) : SIZE_W'(quo_nx);
        size_al  = (size_min + SIZE_W'(ALIGN_BYTES - 1)) & ALIGN_MASK;
    end

    assign idx_inc  = r_idx + LINK_W'(1);
    assign mul_slot = (t_opcode'(i_req.opcode) == OP_FREE) ?
                      i_req.slot_to_free : r_head[SLOT_W-1:0];
    assign product  = mul_slot * r_size;
    assign mem_raddr = r_head[SLOT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_req       = r_req;
        n_size      = r_size;
        n_count     = r_count;
        n_head      = r_head;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[SLOT_W-1:0];
        mem_wdata   = (idx_inc < r_count) ? idx_inc : LINK_NULL;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                n_rem   = '0;
                n_quo   = DIV_W'(total_sat);
                n_dvs   = req_clamp;
                n_cnt   = DIV_CNT_W'(DIV_W - 1);
                n_state = S_DIV_SIZE;
            end
            S_DIV_SIZE: begin
                n_rem = rem_nx;
                n_quo = quo_nx;
                n_cnt = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_size  = size_al;
                    n_rem   = '0;
                    n_quo   = DIV_W'(total_sat);
                    n_dvs   = DIV_W'(size_al);
                    n_cnt   = DIV_CNT_W'(DIV_W - 1);
                    n_state = S_DIV_COUNT;
                end
            end
            S_DIV_COUNT: begin
                n_rem = rem_nx;
                n_quo = quo_nx;
                n_cnt = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_count = (quo_nx > DIV_W'(MAX_SLOTS)) ?
                              LINK_W'(MAX_SLOTS) : quo_nx[LINK_W-1:0];
                    n_idx   = '0;
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                // ascending chain, last live slot points to null
                mem_we = 1'b1;
                n_idx  = idx_inc;
                if (r_idx == LINK_W'(MAX_SLOTS - 1)) begin
                    n_head  = (r_count != '0) ? '0 : LINK_NULL;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (in_fire) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = ST_OK;
                    n_out.slot_number = mul_slot;
                    n_out.byte_offset = product[OFFSET_W-1:0];
                    if (t_opcode'(i_req.opcode) == OP_ALLOC) begin
                        if (r_head >= r_count) begin
                            n_out.status      = ST_EMPTY;
                            n_out.slot_number = '0;
                            n_out.byte_offset = '0;
                        end else if (i_req.request_bytes > r_size) begin
                            n_out.status      = ST_TOO_LARGE;
                            n_out.slot_number = '0;
                            n_out.byte_offset = '0;
                        end else begin
                            // link of the popped slot arrives next cycle
                            n_state = S_POP;
                        end
                    end else begin
                        if ({1'b0, i_req.slot_to_free} >= r_count) begin
                            n_out.status      = ST_NOT_IN_POOL;
                            n_out.slot_number = '0;
                            n_out.byte_offset = '0;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = i_req.slot_to_free;
                            mem_wdata = r_head;
                            n_head    = {1'b0, i_req.slot_to_free};
                        end
                    end
                end
            end
            S_POP: begin
                n_head  = r_rdata;
                n_state = S_RUN;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        // a config write restarts derivation and relinking
        if (i_cfg_we) begin
            if (i_cfg_index == CFG_TOTAL_BYTES) begin
                n_total = i_cfg_data[TOTAL_W-1:0];
                n_state = S_INIT;
            end else if (i_cfg_index == CFG_REQUESTED_SLOTS) begin
                n_req   = i_cfg_data[REQ_W-1:0];
                n_state = S_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_total     <= TOTAL_RESET;
            r_req       <= REQ_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_req       <= n_req;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_count <= n_count;
        r_head  <= n_head;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

endmodule
`default_nettype wire
